@@ sv/dvr_pkg.sv @@
// shared types and constants for the distance vector routing block
package dvr_pkg;

  // fixed widths of the channel words and the configuration register
  localparam int COST_IN_W = 16;
  localparam int IDX_OUT_W = 3;
  localparam int DIST_OUT_W = 16;
  localparam int CFG_W = 4;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RSTART,
    ST_RHEAD,
    ST_RCMP,
    ST_RWB,
    ST_DRD,
    ST_DLD,
    ST_DOUT
  } dvr_state_t;

endpackage

@@ sv/dvr_in_if.sv @@
// input channel: one link cost per word
interface dvr_in_if;
  logic                           valid;
  logic                           ready;
  logic [dvr_pkg::COST_IN_W-1:0]  cost;

  modport source (output valid, output cost, input ready);
  modport sink (input valid, input cost, output ready);
endinterface

@@ sv/dvr_out_if.sv @@
// result channel: one routing table entry per word
interface dvr_out_if;
  logic                           valid;
  logic                           ready;
  logic [dvr_pkg::IDX_OUT_W-1:0]  router;
  logic [dvr_pkg::IDX_OUT_W-1:0]  destination;
  logic [dvr_pkg::IDX_OUT_W-1:0]  next_hop;
  logic [dvr_pkg::DIST_OUT_W-1:0] distance;
  logic                           last;

  modport source (output valid, output router, output destination, output next_hop,
                  output distance, output last, input ready);
  modport sink (input valid, input router, input destination, input next_hop,
                input distance, input last, output ready);
endinterface

@@ sv/dvr_ram.sv @@
// generic simple dual port ram with registered read
module dvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dvr_engine.sv @@
// load, relaxation and dump sequencer around the link cost and route memories
module dvr_engine #(
  parameter int MAX_NODES = 8,
  parameter int COST_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(MAX_NODES)-1:0] n_last,
  input  logic                         restart,
  dvr_in_if.sink                       in_ch,
  dvr_out_if.source                    out_ch
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int AW = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = COST_BITS;
  localparam int RW = CW + IW;
  localparam int OW = dvr_pkg::IDX_OUT_W;
  localparam int DW = dvr_pkg::DIST_OUT_W;
  localparam int INW = dvr_pkg::COST_IN_W;

  dvr_pkg::dvr_state_t state_r, state_nxt;

  logic [IW-1:0] row_r, row_nxt;
  logic [IW-1:0] col_r, col_nxt;
  logic [IW-1:0] via_r, via_nxt;
  logic [CW-1:0] cur_dist_r, cur_dist_nxt;
  logic [IW-1:0] cur_hop_r, cur_hop_nxt;
  logic          changed_r, changed_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_router_r, out_router_nxt;
  logic [IW-1:0] out_dest_r, out_dest_nxt;
  logic [IW-1:0] out_hop_r, out_hop_nxt;
  logic [CW-1:0] out_dist_r, out_dist_nxt;
  logic          out_last_r, out_last_nxt;

  // memory ports
  logic          lk_we;
  logic [AW-1:0] lk_waddr, lk_raddr;
  logic [CW-1:0] lk_wdata, lk_rdata;
  logic          rt_we;
  logic [AW-1:0] rt_waddr, rt_raddr;
  logic [RW-1:0] rt_wdata, rt_rdata;

  dvr_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  dvr_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_route_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  // incoming cost cut or extended to the internal cost width
  logic [CW+INW-1:0] cost_ext;
  logic [CW-1:0]     cost_v;
  assign cost_ext = {{CW{1'b0}}, in_ch.cost};
  assign cost_v   = cost_ext[CW-1:0];

  // table walk helpers
  logic          col_wrap, last_entry, diag;
  logic [IW-1:0] via_inc;
  assign col_wrap   = (col_r == n_last);
  assign last_entry = col_wrap && (row_r == n_last);
  assign diag       = (row_r == col_r);
  assign via_inc    = via_r + IW'(1);

  // relaxation candidate, own entry forwarded from the working register
  logic [CW-1:0] rt_rdist, via_dist, cand;
  logic [IW-1:0] rt_rhop;
  logic [CW:0]   sum;
  assign rt_rdist = rt_rdata[RW-1:IW];
  assign rt_rhop  = rt_rdata[IW-1:0];
  assign via_dist = (via_r == row_r) ? cur_dist_r : rt_rdist;
  assign sum      = {1'b0, lk_rdata} + {1'b0, via_dist};
  assign cand     = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvr_pkg::ST_LOAD;
      row_r       <= '0;
      col_r       <= '0;
      via_r       <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      via_r       <= via_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_dist_r   <= cur_dist_nxt;
    cur_hop_r    <= cur_hop_nxt;
    out_router_r <= out_router_nxt;
    out_dest_r   <= out_dest_nxt;
    out_hop_r    <= out_hop_nxt;
    out_dist_r   <= out_dist_nxt;
    out_last_r   <= out_last_nxt;
  end

  // next state, memory control and result register
  always_comb begin
    logic [IW-1:0] row_adv, col_adv;
    row_adv = col_wrap ? row_r + IW'(1) : row_r;
    col_adv = col_wrap ? '0 : col_r + IW'(1);
    if (last_entry) begin
      row_adv = '0;
      col_adv = '0;
    end

    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    via_nxt        = via_r;
    cur_dist_nxt   = cur_dist_r;
    cur_hop_nxt    = cur_hop_r;
    changed_nxt    = changed_r;
    out_valid_nxt  = out_valid_r;
    out_router_nxt = out_router_r;
    out_dest_nxt   = out_dest_r;
    out_hop_nxt    = out_hop_r;
    out_dist_nxt   = out_dist_r;
    out_last_nxt   = out_last_r;

    lk_we    = 1'b0;
    lk_waddr = {row_r, col_r};
    lk_wdata = diag ? '0 : cost_v;
    lk_raddr = {row_r, via_r};
    rt_we    = 1'b0;
    rt_waddr = {row_r, col_r};
    rt_wdata = {(diag ? {CW{1'b0}} : cost_v), col_r};
    rt_raddr = {row_r, col_r};

    case (state_r)
      dvr_pkg::ST_LOAD: begin
        if (restart) begin
          row_nxt = '0;
          col_nxt = '0;
        end else if (in_ch.valid) begin
          // link cost and initial route written side by side
          lk_we   = 1'b1;
          rt_we   = 1'b1;
          row_nxt = row_adv;
          col_nxt = col_adv;
          if (last_entry) begin
            changed_nxt = 1'b0;
            state_nxt   = dvr_pkg::ST_RSTART;
          end
        end
      end
      dvr_pkg::ST_RSTART: begin
        rt_raddr  = {row_r, col_r};
        state_nxt = dvr_pkg::ST_RHEAD;
      end
      dvr_pkg::ST_RHEAD: begin
        // take the entry being relaxed, start the via scan
        cur_dist_nxt = rt_rdist;
        cur_hop_nxt  = rt_rhop;
        lk_raddr     = {row_r, {IW{1'b0}}};
        rt_raddr     = {{IW{1'b0}}, col_r};
        via_nxt      = '0;
        state_nxt    = dvr_pkg::ST_RCMP;
      end
      dvr_pkg::ST_RCMP: begin
        if (cur_dist_r > cand) begin
          cur_dist_nxt = cand;
          cur_hop_nxt  = via_r;
          changed_nxt  = 1'b1;
        end
        lk_raddr = {row_r, via_inc};
        rt_raddr = {via_inc, col_r};
        if (via_r == n_last) begin
          state_nxt = dvr_pkg::ST_RWB;
        end else begin
          via_nxt = via_inc;
        end
      end
      dvr_pkg::ST_RWB: begin
        rt_we    = 1'b1;
        rt_wdata = {cur_dist_r, cur_hop_r};
        row_nxt  = row_adv;
        col_nxt  = col_adv;
        if (last_entry) begin
          if (changed_r) begin
            changed_nxt = 1'b0;
            state_nxt   = dvr_pkg::ST_RSTART;
          end else begin
            state_nxt = dvr_pkg::ST_DRD;
          end
        end else begin
          state_nxt = dvr_pkg::ST_RSTART;
        end
      end
      dvr_pkg::ST_DRD: begin
        rt_raddr  = {row_r, col_r};
        state_nxt = dvr_pkg::ST_DLD;
      end
      dvr_pkg::ST_DLD: begin
        // table entry into the result register
        out_valid_nxt  = 1'b1;
        out_router_nxt = row_r;
        out_dest_nxt   = col_r;
        out_hop_nxt    = rt_rhop;
        out_dist_nxt   = rt_rdist;
        out_last_nxt   = last_entry;
        row_nxt        = row_adv;
        col_nxt        = col_adv;
        state_nxt      = dvr_pkg::ST_DOUT;
      end
      dvr_pkg::ST_DOUT: begin
        rt_raddr = {row_r, col_r};
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? dvr_pkg::ST_LOAD : dvr_pkg::ST_DLD;
        end
      end
      default: begin
        state_nxt = dvr_pkg::ST_LOAD;
      end
    endcase
  end

  // result word, widened or cut to the channel widths
  logic [OW+IW-1:0] router_ext, dest_ext, hop_ext;
  logic [DW+CW-1:0] dist_ext;
  assign router_ext = {{OW{1'b0}}, out_router_r};
  assign dest_ext   = {{OW{1'b0}}, out_dest_r};
  assign hop_ext    = {{OW{1'b0}}, out_hop_r};
  assign dist_ext   = {{DW{1'b0}}, out_dist_r};

  assign in_ch.ready        = (state_r == dvr_pkg::ST_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.router      = router_ext[OW-1:0];
  assign out_ch.destination = dest_ext[OW-1:0];
  assign out_ch.next_hop    = hop_ext[OW-1:0];
  assign out_ch.distance    = dist_ext[DW-1:0];
  assign out_ch.last        = out_last_r;

endmodule

@@ sv/distance_vector_routing.sv @@
// top level of the distance vector routing table builder
// Costs come in one word per cycle, row-major over num_nodes x num_nodes (diagonal taken as
// zero); a configuration write sets num_nodes (held to 2..MAX_NODES) and, while loading, restarts the load.
// When the matrix is complete the block stops taking words and relaxes the table in place
// with a Bellman-Ford sweep over one link cost memory and one route memory, each with a
// single read and a single write port, scanning one via per cycle through the memory read for
// each table entry of a pass; passes repeat until one makes no change. The table is then sent
// as n*n result words, one at a time, each held while the output stalls, the final word
// marked last, after which costs are taken again.
module distance_vector_routing #(
  parameter int MAX_NODES = 8,
  parameter int COST_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [dvr_pkg::CFG_W-1:0] cfg_wdata,
  dvr_in_if.sink                   in_ch,
  dvr_out_if.source                out_ch
);

  localparam int IW = $clog2(MAX_NODES);
  localparam logic [dvr_pkg::CFG_W-1:0] MaxN = dvr_pkg::CFG_W'(MAX_NODES);
  localparam logic [dvr_pkg::CFG_W-1:0] MinN = dvr_pkg::CFG_W'(2);

  logic [IW-1:0]             n_last_r, n_last_nxt;
  logic [dvr_pkg::CFG_W-1:0] n_clamp, n_minus;

  // node count held to the supported range
  always_comb begin
    if (cfg_wdata < MinN) begin
      n_clamp = MinN;
    end else if (cfg_wdata > MaxN) begin
      n_clamp = MaxN;
    end else begin
      n_clamp = cfg_wdata;
    end
    n_minus    = n_clamp - dvr_pkg::CFG_W'(1);
    n_last_nxt = cfg_we ? n_minus[IW-1:0] : n_last_r;
  end

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_last_r <= IW'(MAX_NODES - 1);
    end else begin
      n_last_r <= n_last_nxt;
    end
  end

  dvr_engine #(.MAX_NODES(MAX_NODES), .COST_BITS(COST_BITS)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .n_last  (n_last_r),
    .restart (cfg_we),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule

@@ sv/dvr_checker.sv @@
// port level checks for the distance vector routing block and their binding
module dvr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // no cost taken while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result word is pending");

  // end of the dump reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("input not reopened after last result word");

  // mid dump the input stays closed
  a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input reopened before last result word");

endmodule

bind distance_vector_routing dvr_checker u_dvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);
